[hw/rtl/slcd_pkg.sv]
// Shared types and constants of the sync, length and checksum deframer.
`default_nettype none

package slcd_pkg;

  // Widths of the fixed payload fields.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned LenW    = 32;

  // Default width of the frame byte counter.
  localparam int unsigned CountWidthDefault = 16;

  // Result queue depth and the most results one request can cause.
  localparam int unsigned ResDepth   = 4;
  localparam int unsigned ResPtrW    = $clog2(ResDepth);
  localparam int unsigned ResCntW    = $clog2(ResDepth + 1);
  localparam int unsigned MaxResults = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;

  // Reset values of the sync pair.
  localparam logic [ByteW-1:0] SyncFirstReset  = 8'hF3;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'hFC;

  // Shortest legal frame: sync pair, two command bytes, four length bytes and one more.
  localparam logic [LenW-1:0] MinFrameLen = 32'd9;

  // Frame status carried by each result.
  typedef enum logic [StatusW-1:0] {
    StProgress = 2'd0,
    StGood     = 2'd1,
    StChecksum = 2'd2,
    StLength   = 2'd3
  } status_e;

  // Deframer phase, one-hot.
  typedef enum logic [2:0] {
    PhHunt   = 3'b001,
    PhHeader = 3'b010,
    PhBody   = 3'b100
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
    logic             last;
    status_e          status;
  } res_t;

  // Results produced by one request, handed to the result queue.
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } res_push_t;

endpackage

`default_nettype wire

[hw/rtl/sync_length_checksum_deframer_core.sv]
// Top level of the sync, length and checksum deframer.
`default_nettype none

// The deframer takes one received byte per request and hunts for the configured
// two-byte sync pair. A frame is the sync pair, two command bytes, a four-byte
// big-endian total length and body bytes up to that length; every frame byte is
// passed out as it arrives, the first sync byte marked with start and the final
// byte marked with last and a status: good when the 8-bit sum of all frame bytes
// is zero, checksum error otherwise, or length error on the last length byte when
// the length is below 9 or beyond the byte counter. Bytes outside a frame give no
// output. A byte is registered on acceptance and parsed in the next cycle, when
// its results are written into the result queue, from which the first of them
// can be taken at the output. While the output is not stalled, one byte per
// cycle is sustained, apart from a stall after each sync pair. A detected sync
// pair yields two results from one byte, which a four-entry result queue
// absorbs; the input stalls only when that queue could not take the results of
// the byte already registered plus those of a new one. The user must write
// configuration only while no frame is in flight; the block does not enforce it.
module sync_length_checksum_deframer_core
  import slcd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_wdata_i,
  input  wire logic               rx_valid_i,
  output logic                    rx_stall_o,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output logic                    frame_valid_o,
  input  wire logic               frame_stall_i,
  output logic [ByteW-1:0]        frame_byte_o,
  output logic                    frame_start_o,
  output logic                    frame_last_o,
  output logic [StatusW-1:0]      frame_status_o
);

  logic [ByteW-1:0]   sync_first_q;
  logic [ByteW-1:0]   sync_second_q;
  logic               req_valid_q;
  logic [ByteW-1:0]   req_byte_q;
  logic               rx_accept;
  res_push_t          push;
  res_t               head;
  logic [ResCntW-1:0] res_count;
  logic [ResCntW:0]   res_need;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgSyncFirst) begin
        sync_first_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CfgSyncSecond) begin
        sync_second_q <= cfg_wdata_i;
      end
    end
  end

  // Accept only when the queue holds room for the registered and the new request.
  assign res_need   = (ResCntW + 1)'(res_count) + (ResCntW + 1)'(push.num)
                    + (ResCntW + 1)'(MaxResults);
  assign rx_stall_o = (res_need > (ResCntW + 1)'(ResDepth));
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= rx_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      req_byte_q <= rx_byte_i;
    end
  end

  // Frame parser.
  slcd_deframe #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_deframe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_q),
    .req_byte_i   (req_byte_q),
    .sync_first_i (sync_first_q),
    .sync_second_i(sync_second_q),
    .push_o       (push)
  );

  // Result queue.
  slcd_res_queue u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .valid_o(frame_valid_o),
    .pop_i  (!frame_stall_i),
    .head_o (head),
    .count_o(res_count)
  );

  assign frame_byte_o   = head.data;
  assign frame_start_o  = head.start;
  assign frame_last_o   = head.last;
  assign frame_status_o = head.status;

endmodule

`default_nettype wire

[hw/rtl/slcd_deframe.sv]
// Frame parser: sync hunt, header decode, byte count and running checksum.
`default_nettype none

module slcd_deframe
  import slcd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire logic [ByteW-1:0] req_byte_i,
  input  wire logic [ByteW-1:0] sync_first_i,
  input  wire logic [ByteW-1:0] sync_second_i,
  output res_push_t             push_o
);

  phase_e                 phase_q, phase_d;
  logic [ByteW-1:0]       prev_q, prev_d;
  logic                   prev_valid_q, prev_valid_d;
  logic [2:0]             hcnt_q, hcnt_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]       sum_q, sum_d;
  logic [LenW-1:0]        len_shift;
  logic                   len_bad;
  logic                   is_sync;

  // Length field with the current byte shifted in, and its range check.
  assign len_shift = {len_q[LenW-ByteW-1:0], req_byte_i};
  assign len_bad   = (len_shift < MinFrameLen) || ((len_shift >> COUNT_WIDTH) != '0);
  assign is_sync   = prev_valid_q && (prev_q == sync_first_i) && (req_byte_i == sync_second_i);

  // Next state and results of the request in the input register.
  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    hcnt_d       = hcnt_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    push_o       = '0;
    push_o.first.status  = StProgress;
    push_o.second.status = StProgress;
    if (req_valid_i) begin
      case (phase_q)
        PhHunt: begin
          if (is_sync) begin
            push_o.num          = 2'd2;
            push_o.first.data   = sync_first_i;
            push_o.first.start  = 1'b1;
            push_o.second.data  = req_byte_i;
            phase_d      = PhHeader;
            hcnt_d       = '0;
            len_d        = '0;
            cnt_d        = COUNT_WIDTH'(2);
            sum_d        = sync_first_i + req_byte_i;
            prev_valid_d = 1'b0;
            prev_d       = '0;
          end else begin
            prev_d       = req_byte_i;
            prev_valid_d = 1'b1;
          end
        end
        PhHeader: begin
          sum_d             = sum_q + req_byte_i;
          cnt_d             = cnt_q + COUNT_WIDTH'(1);
          hcnt_d            = hcnt_q + 3'd1;
          push_o.num        = 2'd1;
          push_o.first.data = req_byte_i;
          if (hcnt_q >= 3'd2) begin
            len_d = len_shift;
          end
          // The last length byte decides whether the frame goes on.
          if (hcnt_q == 3'd5) begin
            if (len_bad) begin
              push_o.first.last   = 1'b1;
              push_o.first.status = StLength;
              phase_d      = PhHunt;
              prev_valid_d = 1'b0;
              prev_d       = '0;
              hcnt_d       = '0;
              len_d        = '0;
              cnt_d        = '0;
              sum_d        = '0;
            end else begin
              phase_d = PhBody;
            end
          end
        end
        PhBody: begin
          sum_d             = sum_q + req_byte_i;
          cnt_d             = cnt_q + COUNT_WIDTH'(1);
          push_o.num        = 2'd1;
          push_o.first.data = req_byte_i;
          if (cnt_d == len_q[COUNT_WIDTH-1:0]) begin
            push_o.first.last   = 1'b1;
            push_o.first.status = (sum_d == '0) ? StGood : StChecksum;
            phase_d      = PhHunt;
            prev_valid_d = 1'b0;
            prev_d       = '0;
            hcnt_d       = '0;
            len_d        = '0;
            cnt_d        = '0;
            sum_d        = '0;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      hcnt_q       <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      sum_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_q       <= prev_d;
      prev_valid_q <= prev_valid_d;
      hcnt_q       <= hcnt_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/slcd_res_queue.sv]
// Small result queue that takes up to two results a cycle and gives one when popped.
`default_nettype none

module slcd_res_queue
  import slcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire res_push_t          push_i,
  output logic                    valid_o,
  input  wire logic               pop_i,
  output res_t                    head_o,
  output logic [ResCntW-1:0]      count_o
);

  res_t                entry_q [ResDepth];
  logic [ResPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0]  count_q, count_d;
  logic                pop;
  logic [ResPtrW-1:0]  wr_ptr_next;

  assign valid_o     = (count_q != '0);
  assign pop         = pop_i && valid_o;
  assign head_o      = entry_q[rd_ptr_q];
  assign count_o     = count_q;
  assign wr_ptr_next = wr_ptr_q + ResPtrW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(push_i.num);
    rd_ptr_d = pop ? (rd_ptr_q + ResPtrW'(1)) : rd_ptr_q;
    count_d  = count_q + ResCntW'(push_i.num) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage: the first result at the write pointer, the second just after it.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      entry_q[wr_ptr_next] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

[test/tb_sync_length_checksum_deframer_core.sv]
// Self-checking testbench for the sync, length and checksum deframer core.
`timescale 1ns / 100ps

module tb_sync_length_checksum_deframer_core;
  import slcd_pkg::*;

  localparam int unsigned     CountW        = CountWidthDefault;
  localparam longint unsigned CountMax      = (64'd1 << CountW) - 64'd1;
  // Register indexes that the block has no register behind.
  localparam logic [CfgIdxW-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = 2'd3;
  // Cycles allowed for a request still in the pipeline that gives no result.
  localparam int unsigned     SettleCycles  = 8;
  localparam int unsigned     WatchdogLimit = 2000;
  localparam int unsigned     MaxReports    = 40;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [ByteW-1:0]   cfg_wdata_i   = '0;
  logic               rx_valid_i    = 1'b0;
  logic               rx_stall_o;
  logic [ByteW-1:0]   rx_byte_i     = '0;
  logic               frame_valid_o;
  logic               frame_stall_i = 1'b0;
  logic [ByteW-1:0]   frame_byte_o;
  logic               frame_start_o;
  logic               frame_last_o;
  logic [StatusW-1:0] frame_status_o;

  sync_length_checksum_deframer_core #(
    .COUNT_WIDTH(CountW)
  ) dut (.*);

  // Shadow of the configuration and the parser state.
  logic [ByteW-1:0]  cfg_sync_first;
  logic [ByteW-1:0]  cfg_sync_second;
  phase_e            parse_phase;
  logic [ByteW-1:0]  hunt_prev;
  bit                hunt_prev_ok;
  int unsigned       hdr_seen;
  logic [LenW-1:0]   len_field;
  logic [CountW-1:0] frame_bytes;
  logic [ByteW-1:0]  frame_sum;

  // Frame bytes predicted but not yet seen at the output.
  res_t frame_bytes_due[$];

  int unsigned      mismatches = 0;
  int unsigned      rx_taken   = 0;
  int unsigned      tx_calm    = 0;
  int unsigned      out_calm   = 0;
  logic [ByteW-1:0] stim_sum   = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Idle length for either side: mostly none or short, now and then long,
  // with occasional calm stretches that have no idling at all.
  function automatic int unsigned pick_idle_len(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void restart_hunt();
    parse_phase  = PhHunt;
    hunt_prev    = '0;
    hunt_prev_ok = 1'b0;
    hdr_seen     = 0;
    len_field    = '0;
    frame_bytes  = '0;
    frame_sum    = '0;
  endfunction

  function automatic void push_frame_byte(input logic [ByteW-1:0] data, input logic start,
                                          input logic last, input status_e status);
    res_t r;
    r.data   = data;
    r.start  = start;
    r.last   = last;
    r.status = status;
    frame_bytes_due = {frame_bytes_due, r};
  endfunction

  // Works out the frame bytes that one received byte causes.
  function automatic void deframe_byte(input logic [ByteW-1:0] b);
    if (parse_phase == PhHunt) begin
      if (hunt_prev_ok && hunt_prev == cfg_sync_first && b == cfg_sync_second) begin
        push_frame_byte(cfg_sync_first, 1'b1, 1'b0, StProgress);
        push_frame_byte(b, 1'b0, 1'b0, StProgress);
        parse_phase  = PhHeader;
        hdr_seen     = 0;
        len_field    = '0;
        frame_bytes  = CountW'(2);
        frame_sum    = cfg_sync_first + b;
        hunt_prev_ok = 1'b0;
        hunt_prev    = '0;
      end else begin
        hunt_prev    = b;
        hunt_prev_ok = 1'b1;
      end
      return;
    end
    frame_sum   = frame_sum + b;
    frame_bytes = frame_bytes + 1'b1;
    if (parse_phase == PhHeader) begin
      if (hdr_seen >= 2) len_field = {len_field[LenW-9:0], b};
      hdr_seen++;
      if (hdr_seen >= 6) begin
        if (len_field < MinFrameLen || 64'(len_field) > CountMax) begin
          push_frame_byte(b, 1'b0, 1'b1, StLength);
          restart_hunt();
          return;
        end
        parse_phase = PhBody;
      end
      push_frame_byte(b, 1'b0, 1'b0, StProgress);
      return;
    end
    if (LenW'(frame_bytes) == len_field) begin
      push_frame_byte(b, 1'b0, 1'b1, (frame_sum == '0) ? StGood : StChecksum);
      restart_hunt();
      return;
    end
    push_frame_byte(b, 1'b0, 1'b0, StProgress);
  endfunction

  // Sends one received byte and waits for its request to be taken.
  task automatic send_rx_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = pick_idle_len(tx_calm);
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(negedge clk_i); while (rx_stall_o);
    @(posedge clk_i);
    stim_sum = stim_sum + b;
    rx_taken++;
    deframe_byte(b);
  endtask

  // Holds the input off until every predicted frame byte has come out.
  task automatic wait_frames_done();
    rx_valid_i <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Completes whatever frame the parser is in, so that it is hunting again.
  task automatic finish_open_frame();
    while (parse_phase != PhHunt) send_rx_byte(8'hFF);
  endtask

  task automatic write_sync_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    finish_open_frame();
    wait_frames_done();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSyncFirst) cfg_sync_first = val;
    else if (idx == CfgSyncSecond) cfg_sync_second = val;
  endtask

  // Sync pair, command bytes and big-endian length; restarts the byte sum.
  task automatic send_frame_head(input logic [ByteW-1:0] cmd0, input logic [ByteW-1:0] cmd1,
                                 input logic [LenW-1:0] len);
    stim_sum = '0;
    send_rx_byte(cfg_sync_first);
    send_rx_byte(cfg_sync_second);
    send_rx_byte(cmd0);
    send_rx_byte(cmd1);
    send_rx_byte(len[31:24]);
    send_rx_byte(len[23:16]);
    send_rx_byte(len[15:8]);
    send_rx_byte(len[7:0]);
  endtask

  // One random sequence: mostly whole frames, some broken ones and noise.
  task automatic send_random_frame();
    int unsigned     kind;
    int unsigned     i;
    logic [LenW-1:0] len;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 3)) send_rx_byte(8'($urandom_range(0, 255)));
    if (kind < 6) begin
      // Sync pair split by a stray byte.
      send_rx_byte(cfg_sync_first);
      send_rx_byte(8'($urandom_range(0, 255)));
      send_rx_byte(cfg_sync_second);
      return;
    end
    if (kind < 10) begin
      repeat ($urandom_range(4, 12)) send_rx_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 16) len = $urandom_range(0, 8);
    else if (kind < 22) len = {16'($urandom_range(1, 65535)), 16'($urandom)};
    else if (kind < 27) len = $urandom_range(41, 300);
    else len = $urandom_range(9, 40);
    send_frame_head(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
    if (len >= MinFrameLen && 64'(len) <= CountMax) begin
      for (i = 8; i + 1 < len; i++) send_rx_byte(8'($urandom_range(0, 255)));
      // Most frames close with a byte that brings the sum to zero.
      if ($urandom_range(0, 2) != 0) send_rx_byte(8'(8'd0 - stim_sum));
      else send_rx_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_frames(input int unsigned n_items);
    int unsigned first_item;
    first_item = rx_taken;
    while (rx_taken - first_item < n_items) begin
      send_random_frame();
      if ($urandom_range(0, 19) == 0) wait_frames_done();
    end
  endtask

  // Short frame that ends good, a stray byte, a split pair and an oversized length.
  task automatic test_directed_frames();
    send_rx_byte(8'h00);
    // The closing byte, the first sync byte, brings the frame sum to zero.
    send_frame_head(8'hFF, 8'h16, MinFrameLen);
    send_rx_byte(SyncFirstReset);
    // The final byte of a frame must not open a new sync pair.
    send_rx_byte(SyncSecondReset);
    send_rx_byte(SyncFirstReset);
    send_rx_byte(8'h00);
    send_rx_byte(SyncSecondReset);
    send_frame_head(8'h00, 8'h00, 32'hFFFF_FFFF);
  endtask

  // The sender waits for a full drain before going on.
  task automatic test_drained_pause();
    repeat (3) send_random_frame();
    wait_frames_done();
  endtask

  task automatic test_reset_sync_pair();
    run_random_frames(200);
  endtask

  // Writes to unused indexes must leave the sync pair alone.
  task automatic test_ignored_registers();
    write_sync_reg(CfgSpareLow, 8'h00);
    write_sync_reg(CfgSpareHigh, 8'hFF);
    run_random_frames(50);
  endtask

  task automatic test_extreme_sync_pairs();
    write_sync_reg(CfgSyncFirst, 8'h00);
    write_sync_reg(CfgSyncSecond, 8'hFF);
    run_random_frames(100);
    write_sync_reg(CfgSyncFirst, 8'hFF);
    write_sync_reg(CfgSyncSecond, 8'h00);
    run_random_frames(100);
  endtask

  task automatic test_equal_sync_pair();
    logic [ByteW-1:0] val;
    val = 8'($urandom_range(0, 255));
    write_sync_reg(CfgSyncFirst, val);
    write_sync_reg(CfgSyncSecond, val);
    run_random_frames(80);
  endtask

  task automatic test_random_sync_pair();
    write_sync_reg(CfgSyncFirst, 8'($urandom_range(0, 255)));
    write_sync_reg(CfgSyncSecond, 8'($urandom_range(0, 255)));
    run_random_frames(80);
  endtask

  // One length beyond the counter, then the longest length it holds, left open.
  task automatic test_longest_frames();
    write_sync_reg(CfgSyncFirst, SyncFirstReset);
    write_sync_reg(CfgSyncSecond, SyncSecondReset);
    send_frame_head(8'h00, 8'h00, LenW'(CountMax + 1));
    send_frame_head(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), LenW'(CountMax));
    repeat (8) send_rx_byte(8'($urandom_range(0, 255)));
  endtask

  // Output stall with random gaps.
  initial begin : frame_stall_gen
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        frame_stall_i <= 1'b1;
        hold--;
      end else begin
        frame_stall_i <= 1'b0;
        hold = pick_idle_len(out_calm);
      end
    end
  end

  // Compares each accepted frame byte with the oldest prediction.
  initial begin : frame_checker
    res_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && frame_valid_o && !frame_stall_i) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unpredicted frame byte %02h", frame_byte_o));
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_byte_o !== want.data)
            report_mismatch($sformatf("byte %02h, want %02h", frame_byte_o, want.data));
          if (frame_start_o !== want.start)
            report_mismatch($sformatf("start %b, want %b on byte %02h",
                                      frame_start_o, want.start, want.data));
          if (frame_last_o !== want.last)
            report_mismatch($sformatf("last %b, want %b on byte %02h",
                                      frame_last_o, want.last, want.data));
          if (frame_status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %s on byte %02h",
                                      frame_status_o, want.status.name(), want.data));
        end
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(negedge clk_i);
      if ((rx_valid_i && !rx_stall_o) || (frame_valid_o && !frame_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : main
    cfg_sync_first  = SyncFirstReset;
    cfg_sync_second = SyncSecondReset;
    restart_hunt();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_drained_pause();
    test_reset_sync_pair();
    test_ignored_registers();
    test_extreme_sync_pairs();
    test_equal_sync_pair();
    test_random_sync_pair();
    test_longest_frames();

    wait_frames_done();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
